// ----- design/mqttrx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MQTT receive parser package
// Sizes, frame type codes and the parse phase type of the receive parser.
// ----------------------------------------------------------------------------
package mqttrx_pkg;

	localparam int BUFFER_BYTES = 512;
	localparam int MAX_PAYLOAD  = 256;

	// stored byte count reaches BUFFER_BYTES itself
	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int LEN_W = 28;
	// topic length plus two, plus two more for the identifier
	localparam int OVH_W = 18;

	localparam logic [3:0] TYPE_CONNACK  = 4'h2;
	localparam logic [3:0] TYPE_PUBLISH  = 4'h3;
	localparam logic [3:0] TYPE_PINGRESP = 4'hD;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

endpackage
`default_nettype wire

// ----- design/mqtt_packet_receive_parser_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MQTT receive packet parser
// Frames a received MQTT byte stream, flags CONNACK, PINGRESP and PUBLISH
// completion, decodes QoS and packet id, and forwards publish payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: rx_byte with in_valid / in_stall. One beat is one byte.
//  - Output channel: one result beat per input beat, out_valid / out_stall,
//    all result fields as separate ports.
//  - A byte's result is registered and shows in the cycle after the byte is
//    taken. Throughput is one byte per cycle while no result is stalled; the
//    parse and result registers load from one pass of logic on the input byte.
//  - While a result waits with out_stall high, in_stall is raised and the
//    held result stays unchanged; once it is taken the next byte is accepted
//    in the same cycle.
//  - cfg_write_en / cfg_write_data set the payload delivery enable; write it
//    only while no byte is in flight.
//  - Reset puts the parser back to waiting for a fixed header byte, clears
//    the delivery enable and empties the result register.
// ----------------------------------------------------------------------------
module mqtt_packet_receive_parser_unit
	import mqttrx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic        cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       packet_type,
	output logic             connack_seen,
	output logic             pingresp_seen,
	output logic             publish_done,
	output logic             puback_needed,
	output logic [1:0]       qos_level,
	output logic [15:0]      packet_ident,
	output logic             payload_valid,
	output logic [7:0]       payload_data,
	output logic             payload_last,
	output logic             frame_dropped
);

	// parse state
	phase_t             phase_q, phase_d;
	logic [7:0]         header_q, header_d;
	logic [LEN_W-1:0]   body_len_q, body_len_d;
	logic [2:0]         len_cnt_q, len_cnt_d;
	logic [CNT_W-1:0]   stored_q, stored_d;
	logic [15:0]        topic_size_q, topic_size_d;
	logic [15:0]        ident_q, ident_d;
	logic               deliver_en_q;

	// result register
	logic               out_valid_q;
	logic [3:0]         ptype_q;
	logic               connack_q, pingresp_q, pubdone_q, puback_q;
	logic [1:0]         qos_q;
	logic [15:0]        ident_out_q;
	logic               pvalid_q, plast_q, dropped_q;
	logic [7:0]         pdata_q;

	// next result
	logic               connack_d, pingresp_d, pubdone_d, puback_d;
	logic [1:0]         qos_out_d;
	logic [15:0]        ident_out_d;
	logic               pvalid_d, plast_d, dropped_d;
	logic [7:0]         pdata_d;

	// body byte decode
	logic [CNT_W-1:0]   lead;
	logic [CNT_W-1:0]   idx;
	logic [1:0]         qos;
	logic               qos_nz;
	logic [OVH_W-1:0]   id_at;
	logic [OVH_W-1:0]   overhead;
	logic [OVH_W-1:0]   idx_w;
	logic               is_pub;
	logic               frame_end;
	logic               fits;
	logic [LEN_W-1:0]   pay_len;
	logic               pay_ok;
	logic [LEN_W-1:0]   len_group;

	logic               in_acc;

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	assign lead     = CNT_W'(len_cnt_q) + CNT_W'(1);
	assign idx      = stored_q - lead;
	assign idx_w    = OVH_W'(idx);
	assign qos      = header_q[2:1];
	assign qos_nz   = |qos;
	assign id_at    = OVH_W'(topic_size_q) + OVH_W'(2);
	assign overhead = id_at + (qos_nz ? OVH_W'(2) : OVH_W'(0));
	assign is_pub   = header_q[7:4] == TYPE_PUBLISH;
	assign frame_end = ({1'b0, LEN_W'(idx)} + (LEN_W + 1)'(1)) >= {1'b0, body_len_q};
	assign fits     = ({1'b0, LEN_W'(lead)} + {1'b0, body_len_q})
		<= (LEN_W + 1)'(BUFFER_BYTES);
	assign pay_len  = body_len_q - LEN_W'(overhead);
	assign pay_ok   = (body_len_q > LEN_W'(overhead)) && (pay_len < LEN_W'(MAX_PAYLOAD));

	// place the 7 data bits of a length byte by its group number
	always_comb begin
		unique case (len_cnt_q[1:0])
			2'd0: len_group = LEN_W'(rx_byte[6:0]);
			2'd1: len_group = LEN_W'(rx_byte[6:0]) << 7;
			2'd2: len_group = LEN_W'(rx_byte[6:0]) << 14;
			2'd3: len_group = LEN_W'(rx_byte[6:0]) << 21;
			default: len_group = '0;
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		header_d     = header_q;
		body_len_d   = body_len_q;
		len_cnt_d    = len_cnt_q;
		stored_d     = stored_q;
		topic_size_d = topic_size_q;
		ident_d      = ident_q;
		connack_d    = 1'b0;
		pingresp_d   = 1'b0;
		pubdone_d    = 1'b0;
		puback_d     = 1'b0;
		qos_out_d    = 2'd0;
		ident_out_d  = 16'd0;
		pvalid_d     = 1'b0;
		pdata_d      = 8'd0;
		plast_d      = 1'b0;
		dropped_d    = 1'b0;

		priority if (phase_q == PH_IDLE) begin
			header_d     = rx_byte;
			phase_d      = PH_LEN;
			body_len_d   = '0;
			len_cnt_d    = 3'd0;
			stored_d     = CNT_W'(1);
			topic_size_d = 16'd0;
			ident_d      = 16'd0;
		end else if (phase_q == PH_LEN) begin
			body_len_d = body_len_q | len_group;
			len_cnt_d  = len_cnt_q + 3'd1;
			if (stored_q < CNT_W'(BUFFER_BYTES)) begin
				stored_d = stored_q + CNT_W'(1);
			end
			if (!rx_byte[7]) begin
				connack_d = header_q[7:4] == TYPE_CONNACK;
				if (body_len_d != '0) begin
					phase_d = PH_BODY;
				end else begin
					pingresp_d = header_q[7:4] == TYPE_PINGRESP;
					phase_d    = PH_IDLE;
				end
			end else if (len_cnt_d >= 3'd4) begin
				// length field too long: drop, next byte is a header
				dropped_d = 1'b1;
				phase_d   = PH_IDLE;
			end
		end else begin
			if (stored_q < CNT_W'(BUFFER_BYTES)) begin
				stored_d = stored_q + CNT_W'(1);
				priority if (idx == CNT_W'(0)) begin
					topic_size_d = {rx_byte, 8'd0};
				end else if (idx == CNT_W'(1)) begin
					topic_size_d = {topic_size_q[15:8], rx_byte};
				end else if (qos_nz && idx_w == id_at) begin
					ident_d = {rx_byte, 8'd0};
				end else if (qos_nz && idx_w == id_at + OVH_W'(1)) begin
					ident_d = {ident_q[15:8], rx_byte};
				end else begin
					ident_d = ident_q;
				end
				if (is_pub && deliver_en_q && idx >= CNT_W'(2) && pay_ok && fits &&
					idx_w >= overhead) begin
					pvalid_d = 1'b1;
					pdata_d  = rx_byte;
					plast_d  = frame_end;
				end
				if (frame_end) begin
					if (is_pub) begin
						pubdone_d = 1'b1;
						qos_out_d = qos;
						if (qos_nz) begin
							puback_d    = 1'b1;
							ident_out_d = ident_d;
						end
					end else begin
						connack_d = header_q[7:4] == TYPE_CONNACK;
					end
					phase_d = PH_IDLE;
				end
			end else begin
				// buffer overrun: discard the byte and the frame
				dropped_d = 1'b1;
				phase_d   = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			header_q     <= 8'd0;
			body_len_q   <= '0;
			len_cnt_q    <= 3'd0;
			stored_q     <= '0;
			topic_size_q <= 16'd0;
			ident_q      <= 16'd0;
		end else if (in_acc) begin
			phase_q      <= phase_d;
			header_q     <= header_d;
			body_len_q   <= body_len_d;
			len_cnt_q    <= len_cnt_d;
			stored_q     <= stored_d;
			topic_size_q <= topic_size_d;
			ident_q      <= ident_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_en_q <= 1'b0;
		end else if (cfg_write_en) begin
			deliver_en_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on every accepted beat
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ptype_q     <= header_d[7:4];
			connack_q   <= connack_d;
			pingresp_q  <= pingresp_d;
			pubdone_q   <= pubdone_d;
			puback_q    <= puback_d;
			qos_q       <= qos_out_d;
			ident_out_q <= ident_out_d;
			pvalid_q    <= pvalid_d;
			pdata_q     <= pdata_d;
			plast_q     <= plast_d;
			dropped_q   <= dropped_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign packet_type   = ptype_q;
	assign connack_seen  = connack_q;
	assign pingresp_seen = pingresp_q;
	assign publish_done  = pubdone_q;
	assign puback_needed = puback_q;
	assign qos_level     = qos_q;
	assign packet_ident  = ident_out_q;
	assign payload_valid = pvalid_q;
	assign payload_data  = pdata_q;
	assign payload_last  = plast_q;
	assign frame_dropped = dropped_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with no result held");

	a_puback_with_publish: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && puback_q |-> pubdone_q && ptype_q == TYPE_PUBLISH && qos_q != 2'd0)
		else $error("puback flagged without a completed publish");

	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && plast_q |-> pvalid_q && pubdone_q)
		else $error("payload last without payload byte or publish end");

	a_drop_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && dropped_q |-> !pubdone_q && !pvalid_q && phase_q == PH_IDLE)
		else $error("dropped frame reported with publish results");

	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> stored_q >= CNT_W'(len_cnt_q) + CNT_W'(1))
		else $error("body phase with fewer bytes held than header and length");

endmodule
`default_nettype wire
